@@ sv/bfsp_pkg.sv @@
package bfsp_pkg;

	// default sizes, used as the defaults of the top level parameters
	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 256;
	localparam int WEIGHT_BITS_DEF  = 16;

	// fixed field widths
	localparam int VIDX_W     = 6;
	localparam int VCNT_W     = 7;
	localparam int DIST_W     = 32;
	localparam int CFG_DATA_W = 7;

	localparam logic [DIST_W-1:0] INF_DIST = 32'h7FFF_FFFF;
	localparam logic [DIST_W-1:0] MIN_DIST = 32'h8000_0000;
	localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;
	localparam logic [VIDX_W-1:0] SRC_RESET  = 6'd0;

	// configuration register indexes
	typedef enum logic {
		REG_VERTEX_COUNT  = 1'b0,
		REG_SOURCE_VERTEX = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_EDGE_RD,
		ST_DIST_RD,
		ST_RELAX,
		ST_OUT_RD,
		ST_OUT_EMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic init;
		logic edge_rd;
		logic relax;
		logic next_edge;
		logic next_pass;
		logic out_rd;
		logic emit;
		logic next_vertex;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic edge_last;
		logic check_pass;
		logic vertex_last;
	} status_t;

endpackage

@@ sv/bellman_ford_shortest_paths.sv @@
// Edge load: one edge per cycle while busy is low; a non-last edge gives no result.
// Run after the last edge: an init state, then vertex_count passes (relaxation and
// check) over the stored edges, each through edge-read, distance-read and relax states.
// Results: one per vertex, each from an output-read and an emit state, after the last pass.
// Reset (arst_n low, asynchronous): edge count, overflow, marks and controller cleared,
// vertex_count back to 64, source_vertex to 0; the stores need no clearing pass.
module bellman_ford_shortest_paths
	import bfsp_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = MAX_EDGES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [VIDX_W-1:0]        edge_from,
	input  logic [VIDX_W-1:0]        edge_to,
	input  logic signed [15:0]       edge_weight,
	input  logic                     last_edge,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output logic                     result_valid,
	output logic [VIDX_W-1:0]        vertex_index,
	output logic signed [DIST_W-1:0] path_distance,
	output logic                     is_reachable,
	output logic [VIDX_W-1:0]        predecessor,
	output logic                     has_predecessor,
	output logic                     negative_cycle,
	output logic                     edges_dropped,
	output logic                     last_vertex
);

	cmd_t    cmd;
	status_t status;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	bfsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_edge (last_edge),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	bfsp_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.edge_from       (edge_from),
		.edge_to         (edge_to),
		.edge_weight     (edge_weight),
		.cmd             (cmd),
		.status          (status),
		.result_valid    (result_valid),
		.vertex_index    (vertex_index),
		.path_distance   (path_distance),
		.is_reachable    (is_reachable),
		.predecessor     (predecessor),
		.has_predecessor (has_predecessor),
		.negative_cycle  (negative_cycle),
		.edges_dropped   (edges_dropped),
		.last_vertex     (last_vertex)
	);

	// results never come in consecutive cycles
	a_result_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe high in two consecutive cycles");

	// a non-last edge transfer leaves the block idle
	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_edge) |=> !busy)
		else $error("block went busy on a non-last edge");

	// the last edge starts a run
	a_last_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_edge) |=> busy)
		else $error("last edge did not start a run");

	// a run ends with the final vertex result
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_valid && last_vertex))
		else $error("run ended without the final vertex result");

endmodule

@@ sv/bfsp_ctrl.sv @@
module bfsp_ctrl
	import bfsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    last_edge,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_edge) begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_EDGE_RD;
			end
			ST_EDGE_RD: begin
				cmd.edge_rd = 1'b1;
				state_d     = ST_DIST_RD;
			end
			ST_DIST_RD: begin
				state_d = ST_RELAX;
			end
			ST_RELAX: begin
				cmd.relax = 1'b1;
				if (status.edge_last) begin
					if (status.check_pass) begin
						state_d = ST_OUT_RD;
					end else begin
						cmd.next_pass = 1'b1;
						state_d       = ST_EDGE_RD;
					end
				end else begin
					cmd.next_edge = 1'b1;
					state_d       = ST_EDGE_RD;
				end
			end
			ST_OUT_RD: begin
				cmd.out_rd = 1'b1;
				state_d    = ST_OUT_EMIT;
			end
			ST_OUT_EMIT: begin
				cmd.emit = 1'b1;
				if (status.vertex_last) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.next_vertex = 1'b1;
					state_d         = ST_OUT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ sv/bfsp_datapath.sv @@
module bfsp_datapath
	import bfsp_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = MAX_EDGES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic [VIDX_W-1:0]       edge_from,
	input  logic [VIDX_W-1:0]       edge_to,
	input  logic signed [15:0]      edge_weight,
	input  cmd_t                    cmd,
	output status_t                 status,
	output logic                    result_valid,
	output logic [VIDX_W-1:0]       vertex_index,
	output logic signed [DIST_W-1:0] path_distance,
	output logic                    is_reachable,
	output logic [VIDX_W-1:0]       predecessor,
	output logic                    has_predecessor,
	output logic                    negative_cycle,
	output logic                    edges_dropped,
	output logic                    last_vertex
);

	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int CW  = (VCW > VCNT_W) ? VCW : VCNT_W;

	// configuration registers
	logic [VCNT_W-1:0] vertex_count_q;
	logic [VIDX_W-1:0] source_vertex_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q  <= VCNT_RESET;
			source_vertex_q <= SRC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERTEX_COUNT:  vertex_count_q  <= cfg_data;
				REG_SOURCE_VERTEX: source_vertex_q <= cfg_data[VIDX_W-1:0];
				default: ;
			endcase
		end
	end

	// vertex count clamped to 1..MAX_VERTICES
	logic [CW-1:0]  vc_raw;
	logic [VCW-1:0] vc_eff;
	assign vc_raw = CW'(vertex_count_q);
	always_comb begin
		if (vc_raw == '0) begin
			vc_eff = VCW'(1);
		end else if (vc_raw > CW'(MAX_VERTICES)) begin
			vc_eff = VCW'(MAX_VERTICES);
		end else begin
			vc_eff = VCW'(vc_raw);
		end
	end

	// run counters
	logic [ECW-1:0] edges_held_q;
	logic           overflow_q;
	logic [EAW-1:0] k_q;
	logic [VCW-1:0] pass_q;
	logic [VAW-1:0] o_q;
	logic           neg_q;
	logic           store_ok;
	assign store_ok = (edges_held_q < ECW'(MAX_EDGES));

	// edge store, one write and one registered read port
	logic [VIDX_W-1:0]      esrc_mem [MAX_EDGES];
	logic [VIDX_W-1:0]      edst_mem [MAX_EDGES];
	logic [WEIGHT_BITS-1:0] ewt_mem  [MAX_EDGES];
	logic [VIDX_W-1:0]      eu_q;
	logic [VIDX_W-1:0]      ev_q;
	logic [WEIGHT_BITS-1:0] ew_q;

	always_ff @(posedge clk) begin
		if (cmd.load && store_ok) begin
			esrc_mem[edges_held_q[EAW-1:0]] <= edge_from;
			edst_mem[edges_held_q[EAW-1:0]] <= edge_to;
			ewt_mem[edges_held_q[EAW-1:0]]  <= WEIGHT_BITS'($unsigned(edge_weight));
		end
		if (cmd.edge_rd) begin
			eu_q <= esrc_mem[k_q];
			ev_q <= edst_mem[k_q];
			ew_q <= ewt_mem[k_q];
		end
	end

	// edge endpoints and range checks
	logic           u_ok;
	logic           v_ok;
	logic           src_ok;
	logic [VAW-1:0] u_a;
	logic [VAW-1:0] v_a;
	logic [VAW-1:0] src_a;
	assign u_ok   = (CW'(eu_q) < CW'(vc_eff));
	assign v_ok   = (CW'(ev_q) < CW'(vc_eff));
	assign src_ok = (CW'(source_vertex_q) < CW'(vc_eff));
	assign u_a    = VAW'(eu_q);
	assign v_a    = VAW'(ev_q);
	assign src_a  = VAW'(source_vertex_q);

	// reach and predecessor marks
	logic [MAX_VERTICES-1:0] reach_q;
	logic [MAX_VERTICES-1:0] predm_q;

	// distance and predecessor stores
	logic [DIST_W-1:0] dist_mem [MAX_VERTICES];
	logic [VAW-1:0]    pred_mem [MAX_VERTICES];
	logic [DIST_W-1:0] dist_a_q;
	logic [DIST_W-1:0] dist_b_q;
	logic [VAW-1:0]    pred_rd_q;
	logic [VAW-1:0]    rd_a;

	// saturating candidate distance
	logic [DIST_W:0]   w_ext;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] cand;
	logic              cand_lt;
	logic              relax_hit;
	logic              apply;

	assign w_ext = {{(DIST_W + 1 - WEIGHT_BITS){ew_q[WEIGHT_BITS-1]}}, ew_q};
	assign sum   = $unsigned($signed({dist_a_q[DIST_W-1], dist_a_q}) + $signed(w_ext));
	always_comb begin
		if (sum[DIST_W] != sum[DIST_W-1]) begin
			cand = sum[DIST_W] ? MIN_DIST : INF_DIST;
		end else begin
			cand = sum[DIST_W-1:0];
		end
	end
	assign cand_lt   = ($signed(cand) < $signed(dist_b_q));
	assign relax_hit = u_ok && v_ok && reach_q[u_a] && (!reach_q[v_a] || cand_lt);
	assign apply     = cmd.relax && relax_hit && !status.check_pass;

	// memory ports: port A serves the edge source or the output vertex
	logic              dist_we;
	logic [VAW-1:0]    dist_wa;
	logic [DIST_W-1:0] dist_wd;
	assign rd_a    = cmd.out_rd ? o_q : u_a;
	assign dist_we = (cmd.init && src_ok) || apply;
	assign dist_wa = cmd.init ? src_a : v_a;
	assign dist_wd = cmd.init ? '0 : cand;

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
		end
		if (apply) begin
			pred_mem[v_a] <= u_a;
		end
		dist_a_q  <= dist_mem[rd_a];
		dist_b_q  <= dist_mem[v_a];
		pred_rd_q <= pred_mem[o_q];
	end

	// control state: counters, marks, flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_held_q <= '0;
			overflow_q   <= 1'b0;
			k_q          <= '0;
			pass_q       <= '0;
			o_q          <= '0;
			neg_q        <= 1'b0;
			reach_q      <= '0;
			predm_q      <= '0;
		end else begin
			if (cmd.finish) begin
				edges_held_q <= '0;
				overflow_q   <= 1'b0;
			end else if (cmd.load) begin
				if (store_ok) begin
					edges_held_q <= edges_held_q + ECW'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (cmd.init) begin
				k_q     <= '0;
				pass_q  <= '0;
				o_q     <= '0;
				neg_q   <= 1'b0;
				predm_q <= '0;
				// only the source starts out reached
				reach_q <= src_ok ? (MAX_VERTICES'(1) << src_a) : '0;
			end
			if (cmd.next_edge) begin
				k_q <= k_q + EAW'(1);
			end
			if (cmd.next_pass) begin
				k_q    <= '0;
				pass_q <= pass_q + VCW'(1);
			end
			if (cmd.next_vertex) begin
				o_q <= o_q + VAW'(1);
			end
			if (apply) begin
				reach_q[v_a] <= 1'b1;
				predm_q[v_a] <= 1'b1;
			end
			if (cmd.relax && relax_hit && status.check_pass) begin
				neg_q <= 1'b1;
			end
		end
	end

	assign status.edge_last   = (ECW'(k_q) == (edges_held_q - ECW'(1)));
	assign status.check_pass  = (pass_q == (vc_eff - VCW'(1)));
	assign status.vertex_last = (VCW'(o_q) == (vc_eff - VCW'(1)));

	// result register, shown for one cycle
	logic              res_valid_q;
	logic [VIDX_W-1:0] res_vertex_q;
	logic [DIST_W-1:0] res_dist_q;
	logic              res_reach_q;
	logic [VIDX_W-1:0] res_pred_q;
	logic              res_has_pred_q;
	logic              res_neg_q;
	logic              res_drop_q;
	logic              res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_vertex_q   <= VIDX_W'(o_q);
			res_dist_q     <= reach_q[o_q] ? dist_a_q : INF_DIST;
			res_reach_q    <= reach_q[o_q];
			res_pred_q     <= predm_q[o_q] ? VIDX_W'(pred_rd_q) : '0;
			res_has_pred_q <= predm_q[o_q];
			res_neg_q      <= neg_q;
			res_drop_q     <= overflow_q;
			res_last_q     <= status.vertex_last;
		end
	end

	assign result_valid    = res_valid_q;
	assign vertex_index    = res_vertex_q;
	assign path_distance   = $signed(res_dist_q);
	assign is_reachable    = res_reach_q;
	assign predecessor     = res_pred_q;
	assign has_predecessor = res_has_pred_q;
	assign negative_cycle  = res_neg_q;
	assign edges_dropped   = res_drop_q;
	assign last_vertex     = res_last_q;

endmodule
